>>> design/ptsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic timer slot pool package
// Shared request and result types, request codes and defaults.
// ----------------------------------------------------------------------------
package ptsp_pkg;

    localparam int NUM_SLOTS_DEFAULT = 8;

    localparam logic REQ_REGISTER = 1'b0;
    localparam logic REQ_TICK     = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] period;
    } request_t;

    typedef struct packed {
        logic [2:0] slot_index;
        logic       pool_full;
        logic [7:0] fire_mask;
    } result_t;

    // One entry of the slot memory.
    typedef struct packed {
        logic [31:0] period;
        logic [31:0] elapsed;
    } slot_word_t;

endpackage

>>> design/ptsp_free_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free slot finder
// Priority encoder that picks the lowest slot whose active mark is clear.
// ----------------------------------------------------------------------------
module ptsp_free_find #(
    parameter int NUM_SLOTS = ptsp_pkg::NUM_SLOTS_DEFAULT,
    parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic [NUM_SLOTS-1:0] active,
    output logic                 found,
    output logic [IDX_W-1:0]     free_idx
);

    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        // Scan from the top so that the lowest free slot wins.
        for (int s = NUM_SLOTS - 1; s >= 0; s--)
        begin
            if (!active[s])
            begin
                found    = 1'b1;
                free_idx = IDX_W'(s);
            end
        end
    end

endmodule

>>> design/periodic_timer_slot_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic timer slot pool
// Pool of periodic timer slots with register and tick requests.
// ----------------------------------------------------------------------------
// A register request keeps busy low, and its result is shown with done in the
// following cycle. A tick request keeps busy high while the slot memory is
// walked one slot per cycle through its single read port and single write
// port; its result is shown with done in the same cycle that busy falls.
// Every result is valid for exactly one cycle while done is high and cannot
// be held off, so the receiver must take it then. Active marks live in
// flip-flops and are cleared by reset, so the block is ready right after
// reset with no clearing pass.
module periodic_timer_slot_pool #(
    parameter int NUM_SLOTS = ptsp_pkg::NUM_SLOTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ptsp_pkg::request_t request,
    output logic               done,
    output ptsp_pkg::result_t  result
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_SLOTS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TICK = 1'b1;

    logic                    state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [NUM_SLOTS-1:0]    active_reg, active_next;
    logic                    proc_valid_reg, proc_valid_next;
    logic [IDX_W-1:0]        proc_idx_reg, proc_idx_next;
    logic [7:0]              fire_reg, fire_next;
    logic                    done_reg, done_next;
    ptsp_pkg::result_t       result_reg, result_next;

    ptsp_pkg::slot_word_t    mem [NUM_SLOTS];
    ptsp_pkg::slot_word_t    rdata_reg;
    ptsp_pkg::slot_word_t    mem_wdata;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [IDX_W-1:0]        mem_raddr;

    logic                    free_found;
    logic [IDX_W-1:0]        free_idx;
    logic                    accept;
    logic [31:0]             elapsed_inc;

    ptsp_free_find #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_free_find (
        .active   (active_reg),
        .found    (free_found),
        .free_idx (free_idx)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    assign mem_raddr   = (cnt_reg < CNT_LAST) ? cnt_reg[IDX_W-1:0] : '0;
    assign elapsed_inc = rdata_reg.elapsed + 32'd1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        active_next     = active_reg;
        proc_valid_next = 1'b0;
        proc_idx_next   = proc_idx_reg;
        fire_next       = fire_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        mem_we          = 1'b0;
        mem_waddr       = free_idx;
        mem_wdata       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.req_type == ptsp_pkg::REQ_REGISTER)
                    begin
                        done_next             = 1'b1;
                        result_next.fire_mask = '0;
                        if (free_found)
                        begin
                            mem_we                 = 1'b1;
                            mem_waddr              = free_idx;
                            mem_wdata.period       = request.period;
                            mem_wdata.elapsed      = '0;
                            active_next[free_idx]  = 1'b1;
                            result_next.slot_index = 3'(free_idx);
                            result_next.pool_full  = 1'b0;
                        end
                        else
                        begin
                            result_next.slot_index = '0;
                            result_next.pool_full  = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = ST_TICK;
                        cnt_next   = '0;
                        fire_next  = '0;
                    end
                end
            end

            ST_TICK:
            begin
                // Read of slot cnt overlaps with write-back of slot cnt - 1,
                // so the two never touch the same entry.
                if (cnt_reg < CNT_LAST)
                begin
                    proc_valid_next = 1'b1;
                    proc_idx_next   = cnt_reg[IDX_W-1:0];
                    cnt_next        = cnt_reg + CNT_W'(1);
                end

                if (proc_valid_reg && active_reg[proc_idx_reg])
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = proc_idx_reg;
                    mem_wdata.period = rdata_reg.period;
                    if (elapsed_inc >= rdata_reg.period)
                    begin
                        mem_wdata.elapsed = '0;
                        // Slots above seven shift out of the mask.
                        fire_next = fire_reg | (8'd1 << proc_idx_reg);
                    end
                    else
                    begin
                        mem_wdata.elapsed = elapsed_inc;
                    end
                end

                if (cnt_reg == CNT_LAST)
                begin
                    state_next             = ST_IDLE;
                    done_next              = 1'b1;
                    result_next.slot_index = '0;
                    result_next.pool_full  = 1'b0;
                    result_next.fire_mask  = fire_next;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            active_reg     <= '0;
            proc_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            active_reg     <= active_next;
            proc_valid_reg <= proc_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg <= proc_idx_next;
        fire_reg     <= fire_next;
        result_reg   <= result_next;
    end

endmodule

>>> bench/periodic_timer_slot_pool_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic timer slot pool testbench
// Drives register and tick requests with random gaps, predicts the slot index,
// full flag and fire mask of every request, and checks each result in order.
// ----------------------------------------------------------------------------
module periodic_timer_slot_pool_tb;

    localparam int SLOTS        = ptsp_pkg::NUM_SLOTS_DEFAULT;
    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT  = 600000;

    class slot_pool_scoreboard;
        logic [31:0]       interval [SLOTS];
        logic [31:0]       elapsed  [SLOTS];
        bit                armed    [SLOTS];
        ptsp_pkg::result_t predicted[$];
        int                errors;

        function new();
            foreach (armed[s])
            begin
                armed[s]    = 1'b0;
                interval[s] = '0;
                elapsed[s]  = '0;
            end
            errors = 0;
        endfunction

        // Works out the result of an accepted request and advances the slots.
        function void note_request(ptsp_pkg::request_t req);
            ptsp_pkg::result_t res;
            bit                claimed;
            res     = '0;
            claimed = 1'b0;
            if (req.req_type == ptsp_pkg::REQ_REGISTER)
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (!claimed && !armed[s])
                    begin
                        interval[s]    = req.period;
                        elapsed[s]     = '0;
                        armed[s]       = 1'b1;
                        res.slot_index = 3'(s);
                        claimed        = 1'b1;
                    end
                end
                if (!claimed)
                    res.pool_full = 1'b1;
            end
            else
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (armed[s])
                    begin
                        elapsed[s] = elapsed[s] + 32'd1;
                        if (elapsed[s] >= interval[s])
                        begin
                            elapsed[s] = '0;
                            if (s < 8)
                                res.fire_mask[s] = 1'b1;
                        end
                    end
                end
            end
            predicted.push_back(res);
        endfunction

        function void check_result(ptsp_pkg::result_t got);
            ptsp_pkg::result_t want;
            if (predicted.size() == 0)
            begin
                $error("result with no request outstanding: %p", got);
                errors++;
                return;
            end
            want = predicted.pop_front();
            if (got.slot_index !== want.slot_index)
            begin
                $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
                errors++;
            end
            if (got.pool_full !== want.pool_full)
            begin
                $error("pool_full: expected %0b, got %0b", want.pool_full, got.pool_full);
                errors++;
            end
            if (got.fire_mask !== want.fire_mask)
            begin
                $error("fire_mask: expected %08b, got %08b", want.fire_mask, got.fire_mask);
                errors++;
            end
        endfunction

        function int outstanding();
            return predicted.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    ptsp_pkg::request_t request;
    logic               done;
    ptsp_pkg::result_t  result;

    slot_pool_scoreboard sb = new();
    int unsigned cycles = 0;
    bit          burst;

    periodic_timer_slot_pool #(.NUM_SLOTS(SLOTS)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Results are checked before the request accepted at the same edge is noted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_request(request);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** periodic_timer_slot_pool: FAILED **");
            $finish;
        end
    end

    function automatic ptsp_pkg::request_t make_req(logic kind, logic [31:0] per);
        ptsp_pkg::request_t req;
        req.req_type = kind;
        req.period   = per;
        return req;
    endfunction

    // Mostly short gaps, a few long ones, and whole stretches without any.
    function automatic int pick_gap();
        int roll;
        if (burst)
            return 0;
        roll = $urandom_range(0, 19);
        if (roll < 10)
            return 0;
        if (roll < 16)
            return $urandom_range(1, 3);
        if (roll < 19)
            return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(ptsp_pkg::request_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_period();
        case ($urandom_range(0, 4))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        ptsp_pkg::request_t directed[$];
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        burst   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // A tick on an empty pool, then slots filled one by one with ticks in
        // between, including a zero interval and one that never expires.
        directed.push_back(make_req(ptsp_pkg::REQ_TICK, 32'hFFFF_FFFF));
        directed.push_back(make_req(ptsp_pkg::REQ_REGISTER, 32'd0));
        directed.push_back(make_req(ptsp_pkg::REQ_TICK, 32'd0));
        directed.push_back(make_req(ptsp_pkg::REQ_REGISTER, 32'd1));
        directed.push_back(make_req(ptsp_pkg::REQ_REGISTER, 32'd3));
        directed.push_back(make_req(ptsp_pkg::REQ_TICK, 32'h5555_5555));
        directed.push_back(make_req(ptsp_pkg::REQ_REGISTER, 32'hFFFF_FFFF));
        directed.push_back(make_req(ptsp_pkg::REQ_REGISTER, 32'd2));
        directed.push_back(make_req(ptsp_pkg::REQ_TICK, 32'hAAAA_AAAA));
        directed.push_back(make_req(ptsp_pkg::REQ_REGISTER, 32'd5));
        directed.push_back(make_req(ptsp_pkg::REQ_REGISTER, 32'd7));
        directed.push_back(make_req(ptsp_pkg::REQ_REGISTER, 32'd4));
        // The pool is full from here on, so registers change nothing.
        directed.push_back(make_req(ptsp_pkg::REQ_REGISTER, 32'd0));
        directed.push_back(make_req(ptsp_pkg::REQ_REGISTER, 32'hFFFF_FFFF));
        for (int i = 0; i < 10; i++)
            directed.push_back(make_req(ptsp_pkg::REQ_TICK, $urandom));
        directed.push_back(make_req(ptsp_pkg::REQ_REGISTER, 32'h8000_0001));

        foreach (directed[i])
            send_request(directed[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 64 == 0)
                burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 8)
                send_request(make_req(ptsp_pkg::REQ_TICK, $urandom));
            else
                send_request(make_req(ptsp_pkg::REQ_REGISTER, random_period()));
        end
        start <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SLOTS + 6) @(posedge clk);

        if (sb.errors == 0)
            $display("** periodic_timer_slot_pool: PASSED **");
        else
            $display("** periodic_timer_slot_pool: FAILED **");
        $finish;
    end

endmodule
